// ----- src/mep_pkg.sv -----
// ============================================================================
// mep_pkg: shared types and constants of the escape-time pixel block
// Field widths, register indexes, defaults and controller/datapath links.
// ============================================================================
package mep_pkg;

   localparam int MAX_ITER_DEF     = 31;
   localparam int FRAC_BITS_DEF    = 24;
   localparam int MAX_HALF_DIM_DEF = 2048;

   localparam int COL_W      = 11;
   localparam int ROW_W      = 13;
   localparam int DIM_REG_W  = 12;
   localparam int MASK_W     = 8;
   localparam int COLOR_W    = 8;
   localparam int REM_W      = 5;
   localparam int IDX_W      = 12;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_PAD_W  = RSP_DATA_W - (COLOR_W + 1 + REM_W + 3 * IDX_W);

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_ADDR_W-1:0] CSR_HALF_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HALF_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_COLOR_MASK  = 2'd2;

   localparam logic [DIM_REG_W-1:0] HALF_WIDTH_RST  = 12'd400;
   localparam logic [DIM_REG_W-1:0] HALF_HEIGHT_RST = 12'd400;
   localparam logic [MASK_W-1:0]    COLOR_MASK_RST  = 8'd255;

   typedef struct packed {
      logic load;
      logic div_step;
      logic fix;
      logic mul;
      logic upd;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic esc_hit;
   } status_type;

endpackage

// ----- src/mep_div.sv -----
// ============================================================================
// mep_div: restoring divider lane, one quotient bit per step
// Divides num * 2^(QUO_W-1) by den; num must not exceed den.
// ============================================================================
module mep_div #(
   parameter int NUM_W = 12,
   parameter int QUO_W = 25
) (
   input  logic             clock,
   input  logic             start,
   input  logic             step,
   input  logic [NUM_W-1:0] num,
   input  logic [NUM_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   logic [NUM_W:0]   rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [NUM_W:0]   diff;
   logic             ge;

   assign diff = rem_ff - {1'b0, den};
   assign ge   = rem_ff >= {1'b0, den};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (start) begin
         rem_in = {1'b0, num};
         quo_in = '0;
      end else if (step) begin
         rem_in = ge ? {diff[NUM_W-1:0], 1'b0} : {rem_ff[NUM_W-1:0], 1'b0};
         quo_in = {quo_ff[QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quo = quo_ff;

endmodule

// ----- src/mep_dpath.sv -----
// ============================================================================
// mep_dpath: datapath of the escape-time pixel block
// Registers, coordinate mapping dividers, complex square unit, result register.
// ============================================================================
module mep_dpath #(
   parameter int MAX_ITER     = 31,
   parameter int FRAC_BITS    = 24,
   parameter int MAX_HALF_DIM = 2048
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [mep_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [mep_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic [mep_pkg::COL_W-1:0]            req_col,
   input  logic signed [mep_pkg::ROW_W-1:0]     req_row,
   input  mep_pkg::cmd_type                     cmd,
   output mep_pkg::status_type                  status,
   output logic [mep_pkg::COLOR_W-1:0]          rsp_color,
   output logic                                 rsp_escaped,
   output logic [mep_pkg::REM_W-1:0]            rsp_remaining,
   output logic [mep_pkg::IDX_W-1:0]            rsp_left_column,
   output logic [mep_pkg::IDX_W-1:0]            rsp_right_column,
   output logic [mep_pkg::IDX_W-1:0]            rsp_row_index
);

   import mep_pkg::*;

   localparam int DIM_W = $clog2(MAX_HALF_DIM + 1);
   localparam int QUO_W = FRAC_BITS + 1;
   localparam int Z_W   = FRAC_BITS + 4;
   localparam int P_W   = FRAC_BITS + 6;
   localparam int S_W   = FRAC_BITS + 7;
   localparam int M_W   = 2 * Z_W;
   localparam int CNT_W = $clog2(MAX_ITER + 1);

   localparam logic signed [S_W-1:0] THRESH   = S_W'((64'd28 << FRAC_BITS) / 64'd10);
   localparam logic signed [Z_W-1:0] HALF_ONE = Z_W'(64'd1 << (FRAC_BITS - 1));

   logic [DIM_REG_W-1:0]    hw_reg_ff, hw_reg_in;
   logic [DIM_REG_W-1:0]    hh_reg_ff, hh_reg_in;
   logic [MASK_W-1:0]       mask_ff, mask_in;

   logic [DIM_W-1:0]        hw_c, hh_c, row_mag;
   logic [COL_W-1:0]        col_c;
   logic signed [31:0]      row_w, row_lo, row_hi;

   logic [DIM_W-1:0]        hw_ff, hh_ff;
   logic                    row_neg_ff;
   logic [IDX_W-1:0]        left_ff, right_ff, rowidx_ff;

   logic [QUO_W-1:0]        qx, qy;
   logic signed [Z_W-1:0]   qy_s;
   logic signed [Z_W-1:0]   cx_ff, cy_ff;
   logic signed [Z_W-1:0]   zr_ff, zr_in, zi_ff, zi_in;
   logic signed [M_W-1:0]   m_rr, m_ii, m_ri;
   logic signed [P_W-1:0]   r2_ff, i2_ff, t_ff;
   logic signed [S_W-1:0]   mag2;
   logic                    esc_hit;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    esc_ff;
   logic [31:0]             cnt_ext;
   logic [REM_W-1:0]        rem_val;

   // configuration registers
   always_comb begin
      hw_reg_in = hw_reg_ff;
      hh_reg_in = hh_reg_ff;
      mask_in   = mask_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_HALF_WIDTH:  hw_reg_in = csr_wdata[DIM_REG_W-1:0];
            CSR_HALF_HEIGHT: hh_reg_in = csr_wdata[DIM_REG_W-1:0];
            CSR_COLOR_MASK:  mask_in   = csr_wdata[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_reg_ff <= HALF_WIDTH_RST;
         hh_reg_ff <= HALF_HEIGHT_RST;
         mask_ff   <= COLOR_MASK_RST;
      end else begin
         hw_reg_ff <= hw_reg_in;
         hh_reg_ff <= hh_reg_in;
         mask_ff   <= mask_in;
      end
   end

   // clamp dimensions and input position
   always_comb begin
      if (hw_reg_ff == '0) hw_c = DIM_W'(1);
      else if (32'(hw_reg_ff) > 32'(MAX_HALF_DIM)) hw_c = DIM_W'(MAX_HALF_DIM);
      else hw_c = DIM_W'(hw_reg_ff);

      if (hh_reg_ff == '0) hh_c = DIM_W'(1);
      else if (32'(hh_reg_ff) > 32'(MAX_HALF_DIM)) hh_c = DIM_W'(MAX_HALF_DIM);
      else hh_c = DIM_W'(hh_reg_ff);

      if (32'(req_col) >= 32'(hw_c)) col_c = COL_W'(hw_c - 1'b1);
      else col_c = req_col;

      row_lo = 32'sd1 - $signed(32'(hh_c));
      row_hi = $signed(32'(hh_c));
      row_w  = 32'(req_row);
      if (row_w < row_lo) row_w = row_lo;
      if (row_w > row_hi) row_w = row_hi;
      row_mag = (row_w < 0) ? DIM_W'(-row_w) : DIM_W'(row_w);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hw_ff      <= hw_c;
         hh_ff      <= hh_c;
         row_neg_ff <= row_w < 0;
         left_ff    <= IDX_W'(32'(hw_c) - 32'(col_c) - 32'd1);
         right_ff   <= IDX_W'(32'(hw_c) + 32'(col_c));
         rowidx_ff  <= IDX_W'(row_w + $signed(32'(hh_c)) - 32'sd1);
      end
   end

   mep_div #(
      .NUM_W (DIM_W),
      .QUO_W (QUO_W)
   ) u_div_x (
      .clock (clock),
      .start (cmd.load),
      .step  (cmd.div_step),
      .num   (DIM_W'(col_c)),
      .den   (hw_ff),
      .quo   (qx)
   );

   mep_div #(
      .NUM_W (DIM_W),
      .QUO_W (QUO_W)
   ) u_div_y (
      .clock (clock),
      .start (cmd.load),
      .step  (cmd.div_step),
      .num   (row_mag),
      .den   (hh_ff),
      .quo   (qy)
   );

   assign qy_s = $signed(Z_W'(qy));

   always_ff @(posedge clock) begin
      if (cmd.fix) begin
         cx_ff <= $signed(Z_W'(qx));
         cy_ff <= (row_neg_ff ? -qy_s : qy_s) - HALF_ONE;
      end
   end

   // complex square: products registered in ST_MUL, update and escape test in ST_UPD
   assign m_rr = zr_ff * zr_ff;
   assign m_ii = zi_ff * zi_ff;
   assign m_ri = zr_ff * zi_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         r2_ff <= P_W'(m_rr >>> FRAC_BITS);
         i2_ff <= P_W'(m_ii >>> FRAC_BITS);
         t_ff  <= P_W'(m_ri >>> FRAC_BITS);
      end
   end

   assign mag2    = S_W'(r2_ff) + S_W'(i2_ff);
   assign esc_hit = mag2 > THRESH;
   assign zr_in   = Z_W'(r2_ff - i2_ff + P_W'(cy_ff));
   assign zi_in   = Z_W'((t_ff <<< 1) + P_W'(cx_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         esc_ff <= 1'b0;
      end else if (cmd.load) begin
         cnt_ff <= CNT_W'(MAX_ITER);
         esc_ff <= 1'b0;
      end else begin
         if (cmd.mul) cnt_ff <= cnt_ff - 1'b1;
         if (cmd.upd && esc_hit) esc_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         zr_ff <= '0;
         zi_ff <= '0;
      end else if (cmd.upd) begin
         zr_ff <= zr_in;
         zi_ff <= zi_in;
      end
   end

   assign status.cnt_zero = cnt_ff == '0;
   assign status.esc_hit  = esc_hit;

   // result register
   assign cnt_ext = 32'(cnt_ff);
   assign rem_val = esc_ff ? cnt_ext[REM_W-1:0] : '1;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_color        <= {rem_val, 3'b000} & mask_ff;
         rsp_escaped      <= esc_ff;
         rsp_remaining    <= rem_val;
         rsp_left_column  <= left_ff;
         rsp_right_column <= right_ff;
         rsp_row_index    <= rowidx_ff;
      end
   end

endmodule

// ----- src/mep_ctrl.sv -----
// ============================================================================
// mep_ctrl: controller of the escape-time pixel block
// Sequences mapping division, iterations and the result transfer.
// ============================================================================
module mep_ctrl #(
   parameter int FRAC_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  mep_pkg::status_type  status,
   output mep_pkg::cmd_type     cmd
);

   import mep_pkg::*;

   localparam int DC_W = $clog2(FRAC_BITS + 1);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DIV  = 6'b000010,
      ST_FIX  = 6'b000100,
      ST_MUL  = 6'b001000,
      ST_UPD  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type       state_ff, state_in;
   logic [DC_W-1:0] div_cnt_ff, div_cnt_in;
   logic            rsp_tvalid_ff, rsp_tvalid_in;

   always_comb begin
      state_in      = state_ff;
      div_cnt_in    = div_cnt_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      cmd           = '0;
      if (rsp_tready) rsp_tvalid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load   = 1'b1;
               div_cnt_in = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DC_W'(FRAC_BITS)) state_in = ST_FIX;
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (status.cnt_zero) begin
               state_in = ST_OUT;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.upd  = 1'b1;
            state_in = status.esc_hit ? ST_OUT : ST_MUL;
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.out_load  = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         div_cnt_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         div_cnt_ff    <= div_cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

// ----- src/mandelbrot_escape_pixel.sv -----
// ============================================================================
// mandelbrot_escape_pixel: escape-time evaluator for one pixel position
// Maps a half-image position to a point c, iterates z = z^2 + c, reports
// the escape count, palette index and the mirrored image coordinates.
// ============================================================================
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------
//  req     | in        | req_tvalid / req_tready | req_tdata  (col, row)
//  rsp     | out       | rsp_tvalid / rsp_tready | rsp_tdata  (result item)
//  csr     | in        | csr_we                  | csr_addr, csr_wdata
//
//  One pixel at a time: a taken request passes through ST_DIV, where the
//  mapping divider makes one quotient bit per cycle, then ST_FIX, then the
//  complex square loop of ST_MUL and ST_UPD once per iteration, then ST_OUT
//  into the result register.
//  Reset clears the controller and loads the register defaults 400, 400, 255.
//  A held result does not block the next pixel until that pixel finishes.
//
module mandelbrot_escape_pixel #(
   parameter int MAX_ITER     = mep_pkg::MAX_ITER_DEF,
   parameter int FRAC_BITS    = mep_pkg::FRAC_BITS_DEF,
   parameter int MAX_HALF_DIM = mep_pkg::MAX_HALF_DIM_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // col [10:0], row [23:11]
   input  logic [mep_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // color [7:0], escaped [8], remaining [13:9], left_column [25:14],
   // right_column [37:26], row_index [49:38], zero [55:50]
   output logic [mep_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_we,
   input  logic [mep_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [mep_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import mep_pkg::*;

   cmd_type                 cmd;
   status_type              status;
   logic [COL_W-1:0]        req_col;
   logic signed [ROW_W-1:0] req_row;
   logic [COLOR_W-1:0]      rsp_color;
   logic                    rsp_escaped;
   logic [REM_W-1:0]        rsp_remaining;
   logic [IDX_W-1:0]        rsp_left_column, rsp_right_column, rsp_row_index;

   assign req_col = req_tdata[COL_W-1:0];
   assign req_row = $signed(req_tdata[COL_W+ROW_W-1:COL_W]);

   mep_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mep_dpath #(
      .MAX_ITER     (MAX_ITER),
      .FRAC_BITS    (FRAC_BITS),
      .MAX_HALF_DIM (MAX_HALF_DIM)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .req_col          (req_col),
      .req_row          (req_row),
      .cmd              (cmd),
      .status           (status),
      .rsp_color        (rsp_color),
      .rsp_escaped      (rsp_escaped),
      .rsp_remaining    (rsp_remaining),
      .rsp_left_column  (rsp_left_column),
      .rsp_right_column (rsp_right_column),
      .rsp_row_index    (rsp_row_index)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_row_index, rsp_right_column,
                       rsp_left_column, rsp_remaining, rsp_escaped, rsp_color};

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("block ready right after taking a pixel");

   a_full_run_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_escaped |-> rsp_remaining == '1)
      else $error("non-escaped pixel without full remaining count");

   a_escape_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_escaped |-> 32'(rsp_remaining) < 32'(MAX_ITER))
      else $error("escaped pixel with remaining count out of range");

endmodule
